FILE: src/mchw_pkg.sv
// ----------------------------------------------------------------------------
// mchw_pkg
// Shared types, codes and constants of the heartbeat watchdog unit.
// ----------------------------------------------------------------------------
package mchw_pkg;

    localparam int MODULES_DEF  = 7;
    localparam int TIMEOUT_REGS = 7;

    localparam int KIND_W   = 2;
    localparam int MOD_W    = 3;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int TOL_W    = 4;
    localparam int TOLREG_W = 28;
    localparam int CFG_W    = 28;
    localparam int IDXREG_W = 3;
    localparam int LOSS_W   = 8;
    localparam int CCNT_W   = 3;

    localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVALUATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET_ONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESET_ALL = 2'd3;

    localparam logic [IDXREG_W-1:0] REG_TOLERANCE = 3'd7;

    localparam logic [TIMEOUT_REGS-1:0][TMO_W-1:0] TIMEOUT_RESET = {
        16'd150, 16'd750, 16'd1000, 16'd750, 16'd7500, 16'd300, 16'd1500
    };
    localparam logic [TOLREG_W-1:0] TOLERANCE_RESET = 28'h3333233;
    localparam logic [LOSS_W-1:0]   LOSS_MAX        = 8'hFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic hb;        // record a heartbeat
        logic clr_one;   // forget one module
        logic clr_all;   // forget every module
        logic start;     // latch time, rewind the walk
        logic step;      // evaluate one module into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic slot_free;  // output register can take a result this cycle
        logic walk_last;  // walk pointer sits on the final module
    } sts_t;

endpackage

FILE: src/multi_channel_heartbeat_watchdog_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit
// Heartbeat watchdog over several modules with per-module timeouts, loss
// counts and criticality tolerances.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  req      req_valid/req_ready  kind, module_req, time_ms
//  rsp      rsp_valid/rsp_ready  module_index, beat_ok, miss_run,
//                                is_critical, crit_flag, crit_tally, last
//  cfg      cfg_we               cfg_index, cfg_data
//
// Heartbeat and reset transactions complete when accepted. An evaluate
// transaction is accepted and then visits each module in turn, carried out
// by the single shared evaluation step walking the module entries.
// A stalled rsp channel holds the walk; req is not taken during a walk.
// Reset clears all modules to never heard; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_unit
#(
    parameter int MODULES = mchw_pkg::MODULES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [mchw_pkg::KIND_W-1:0]   kind,
    input  logic [mchw_pkg::MOD_W-1:0]    module_req,
    input  logic [mchw_pkg::TIME_W-1:0]   time_ms,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [mchw_pkg::MOD_W-1:0]    module_index,
    output logic                          beat_ok,
    output logic [mchw_pkg::LOSS_W-1:0]   miss_run,
    output logic                          is_critical,
    output logic                          crit_flag,
    output logic [mchw_pkg::CCNT_W-1:0]   crit_tally,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [mchw_pkg::IDXREG_W-1:0] cfg_index,
    input  logic [mchw_pkg::CFG_W-1:0]    cfg_data
);

    logic [mchw_pkg::TIMEOUT_REGS-1:0][mchw_pkg::TMO_W-1:0] timeout;
    logic [mchw_pkg::TOLREG_W-1:0]                          tolerance;
    mchw_pkg::cmd_t                                         cmd;
    mchw_pkg::sts_t                                         sts;

    mchw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timeout   (timeout),
        .tolerance (tolerance)
    );

    mchw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .sts       (sts),
        .cmd       (cmd)
    );

    mchw_dp #(
        .MODULES (MODULES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .module_req   (module_req),
        .time_ms      (time_ms),
        .timeout      (timeout),
        .tolerance    (tolerance),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .module_index (module_index),
        .beat_ok      (beat_ok),
        .miss_run     (miss_run),
        .is_critical  (is_critical),
        .crit_flag    (crit_flag),
        .crit_tally   (crit_tally),
        .last         (last)
    );

    // summary fields only on the final result of a walk
    a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !last) |-> (!crit_flag && crit_tally == '0))
        else $error("summary fields set before the last result");

    // a timed-out module always reports a nonzero loss count
    a_loss_when_late: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !beat_ok) |-> (miss_run != '0))
        else $error("not ok with zero loss count");

    // a module within its timeout can never be critical
    a_crit_implies_late: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_critical) |-> !beat_ok)
        else $error("critical module reported ok");

    // an accepted evaluate blocks further requests while the walk runs
    a_walk_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && kind == mchw_pkg::KIND_EVALUATE) |=> !req_ready)
        else $error("request taken during evaluation walk");

endmodule

FILE: src/mchw_cfg.sv
// ----------------------------------------------------------------------------
// mchw_cfg
// Configuration registers: per-module timeouts and packed tolerances.
// ----------------------------------------------------------------------------
module mchw_cfg
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  cfg_we,
    input  logic [mchw_pkg::IDXREG_W-1:0]                         cfg_index,
    input  logic [mchw_pkg::CFG_W-1:0]                            cfg_data,
    output logic [mchw_pkg::TIMEOUT_REGS-1:0][mchw_pkg::TMO_W-1:0] timeout,
    output logic [mchw_pkg::TOLREG_W-1:0]                         tolerance
);

    logic [mchw_pkg::TIMEOUT_REGS-1:0][mchw_pkg::TMO_W-1:0] timeout_reg;
    logic [mchw_pkg::TOLREG_W-1:0]                          tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= mchw_pkg::TIMEOUT_RESET;
            tolerance_reg <= mchw_pkg::TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            if ({29'd0, cfg_index} < mchw_pkg::TIMEOUT_REGS)
            begin
                timeout_reg[cfg_index] <= cfg_data[mchw_pkg::TMO_W-1:0];
            end
            else if (cfg_index == mchw_pkg::REG_TOLERANCE)
            begin
                tolerance_reg <= cfg_data[mchw_pkg::TOLREG_W-1:0];
            end
        end
    end

    assign timeout   = timeout_reg;
    assign tolerance = tolerance_reg;

endmodule

FILE: src/mchw_ctrl.sv
// ----------------------------------------------------------------------------
// mchw_ctrl
// Controller: decodes request transactions and sequences the evaluation walk.
// ----------------------------------------------------------------------------
module mchw_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [mchw_pkg::KIND_W-1:0] kind,
    input  mchw_pkg::sts_t              sts,
    output mchw_pkg::cmd_t              cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        mchw_pkg::KIND_HEARTBEAT: cmd.hb      = 1'b1;
                        mchw_pkg::KIND_RESET_ONE: cmd.clr_one = 1'b1;
                        mchw_pkg::KIND_RESET_ALL: cmd.clr_all = 1'b1;
                        mchw_pkg::KIND_EVALUATE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_EVAL;
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_EVAL:
            begin
                // advance only when the output register has room
                if (sts.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/mchw_dp.sv
// ----------------------------------------------------------------------------
// mchw_dp
// Datapath: per-module heartbeat state, one-module-per-cycle evaluation while
// the output register has room, and the output register.
// ----------------------------------------------------------------------------
module mchw_dp
#(
    parameter int MODULES = mchw_pkg::MODULES_DEF
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  mchw_pkg::cmd_t                                        cmd,
    output mchw_pkg::sts_t                                        sts,
    input  logic [mchw_pkg::MOD_W-1:0]                            module_req,
    input  logic [mchw_pkg::TIME_W-1:0]                           time_ms,
    input  logic [mchw_pkg::TIMEOUT_REGS-1:0][mchw_pkg::TMO_W-1:0] timeout,
    input  logic [mchw_pkg::TOLREG_W-1:0]                         tolerance,
    output logic                                                  rsp_valid,
    input  logic                                                  rsp_ready,
    output logic [mchw_pkg::MOD_W-1:0]                            module_index,
    output logic                                                  beat_ok,
    output logic [mchw_pkg::LOSS_W-1:0]                           miss_run,
    output logic                                                  is_critical,
    output logic                                                  crit_flag,
    output logic [mchw_pkg::CCNT_W-1:0]                           crit_tally,
    output logic                                                  last
);

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int TOT_W = $clog2(MODULES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MODULES - 1);

    // per-module state
    logic [MODULES-1:0][mchw_pkg::TIME_W-1:0] last_seen_reg;
    logic [MODULES-1:0][mchw_pkg::LOSS_W-1:0] miss_reg;
    logic [MODULES-1:0]                       heard_reg;

    logic [mchw_pkg::TIME_W-1:0] now_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [TOT_W-1:0]            crit_tot_reg;

    logic                        out_valid_reg;
    logic [mchw_pkg::MOD_W-1:0]  out_idx_reg;
    logic                        out_ok_reg;
    logic [mchw_pkg::LOSS_W-1:0] out_loss_reg;
    logic                        out_crit_reg;
    logic                        out_any_reg;
    logic [mchw_pkg::CCNT_W-1:0] out_ccnt_reg;
    logic                        out_last_reg;

    // per-module limits; a module past the register list has zero limits
    logic [MODULES-1:0][mchw_pkg::TMO_W-1:0] tmo_vec;
    logic [MODULES-1:0][mchw_pkg::TOL_W-1:0] tol_vec;

    for (genvar m = 0; m < MODULES; m++)
    begin : g_lim
        if (m < mchw_pkg::TIMEOUT_REGS)
        begin : g_reg
            assign tmo_vec[m] = timeout[m];
            assign tol_vec[m] = tolerance[m*mchw_pkg::TOL_W +: mchw_pkg::TOL_W];
        end
        else
        begin : g_zero
            assign tmo_vec[m] = '0;
            assign tol_vec[m] = '0;
        end
    end

    logic                        mod_valid;
    logic [IDX_W-1:0]            mod_sel;
    logic                        hd;
    logic [mchw_pkg::TIME_W-1:0] elapsed;
    logic                        late;
    logic [mchw_pkg::LOSS_W-1:0] miss_cur;
    logic [mchw_pkg::LOSS_W-1:0] miss_new;
    logic                        crit;
    logic [TOT_W-1:0]            crit_tot_new;

    assign mod_valid = ({1'b0, module_req} < 4'(MODULES));
    assign mod_sel   = module_req[IDX_W-1:0];

    assign hd       = heard_reg[idx_reg];
    assign elapsed  = now_reg - last_seen_reg[idx_reg];
    assign late     = (elapsed > {16'd0, tmo_vec[idx_reg]});
    assign miss_cur = miss_reg[idx_reg];

    always_comb
    begin
        if (!late)
        begin
            miss_new = '0;
        end
        else if (miss_cur == mchw_pkg::LOSS_MAX)
        begin
            miss_new = mchw_pkg::LOSS_MAX;
        end
        else
        begin
            miss_new = miss_cur + 8'd1;
        end
    end

    assign crit         = hd && (miss_new > {4'd0, tol_vec[idx_reg]});
    assign crit_tot_new = crit_tot_reg + TOT_W'(crit);

    assign sts.slot_free = !out_valid_reg || rsp_ready;
    assign sts.walk_last = (idx_reg == IDX_LAST);

    // module state; heard flags are the only part that needs clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heard_reg <= '0;
        end
        else
        begin
            priority if (cmd.clr_all)
            begin
                heard_reg <= '0;
            end
            else if (cmd.clr_one && mod_valid)
            begin
                heard_reg[mod_sel] <= 1'b0;
            end
            else if (cmd.hb && mod_valid)
            begin
                heard_reg[mod_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hb && mod_valid)
        begin
            last_seen_reg[mod_sel] <= time_ms;
            miss_reg[mod_sel]      <= '0;
        end
        else if (cmd.step && hd)
        begin
            miss_reg[idx_reg] <= miss_new;
        end
        if (cmd.start)
        begin
            now_reg <= time_ms;
        end
    end

    // walk pointer and critical total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            crit_tot_reg <= '0;
        end
        else if (cmd.start)
        begin
            idx_reg      <= '0;
            crit_tot_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg      <= sts.walk_last ? '0 : idx_reg + 1'b1;
            crit_tot_reg <= crit_tot_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_idx_reg  <= mchw_pkg::MOD_W'(idx_reg);
            out_ok_reg   <= !(hd && late);
            out_loss_reg <= (hd && late) ? miss_new : '0;
            out_crit_reg <= crit;
            out_last_reg <= sts.walk_last;
            out_any_reg  <= sts.walk_last && (crit_tot_new != '0);
            out_ccnt_reg <= sts.walk_last ? mchw_pkg::CCNT_W'(crit_tot_new) : '0;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign module_index = out_idx_reg;
    assign beat_ok      = out_ok_reg;
    assign miss_run     = out_loss_reg;
    assign is_critical  = out_crit_reg;
    assign crit_flag    = out_any_reg;
    assign crit_tally   = out_ccnt_reg;
    assign last         = out_last_reg;

endmodule

FILE: verif/multi_channel_heartbeat_watchdog_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit_tb
// Self-checking bench for the heartbeat watchdog. Heartbeat, reset and
// evaluate transactions go in over the req channel. A tracker class keeps
// its own copy of the per-module state and the timeout and tolerance
// registers, builds the seven status reports that each evaluate should
// produce, and scores every report taken from the rsp channel. Runs cover
// the reset, minimum, maximum and random register settings, random idling
// on both channels, and an evaluate run with zero timeouts that grows the
// loss counts on every evaluate.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_unit_tb;

    localparam int NUM_MODS     = mchw_pkg::MODULES_DEF;
    localparam int SETTLE_CYC   = 16;        // covers one full walk plus slack
    localparam int DRAIN_CAP    = 20000;
    localparam int LIMIT_NS     = 2000000;
    localparam int RANDOM_ITEMS = 14;
    localparam int SAT_EVALS    = 16;

    typedef enum int { CFG_MIN, CFG_MAX, CFG_RANDOM } cfg_mode_t;

    typedef struct packed {
        logic [mchw_pkg::MOD_W-1:0]  module_index;
        logic                        beat_ok;
        logic [mchw_pkg::LOSS_W-1:0] miss_run;
        logic                        is_critical;
        logic                        crit_flag;
        logic [mchw_pkg::CCNT_W-1:0] crit_tally;
        logic                        last;
    } status_report_t;

    // ------------------------------------------------------------------------
    // Tracker: per-module watchdog state and the reports still owed
    // ------------------------------------------------------------------------
    class watchdog_tracker;
        logic [mchw_pkg::TMO_W-1:0]    tmo_limit [NUM_MODS];
        logic [mchw_pkg::TOLREG_W-1:0] tolerance;
        logic [mchw_pkg::TIME_W-1:0]   seen_ms [NUM_MODS];
        logic [mchw_pkg::LOSS_W-1:0]   misses [NUM_MODS];
        bit                            heard [NUM_MODS];
        status_report_t                expected_reports [$];
        int                            errors;

        function void power_on();
            for (int m = 0; m < NUM_MODS; m++)
            begin
                tmo_limit[m] = mchw_pkg::TIMEOUT_RESET[m];
                forget(m);
            end
            tolerance = mchw_pkg::TOLERANCE_RESET;
            errors = 0;
        endfunction

        function void forget(int m);
            seen_ms[m] = '0;
            misses[m]  = '0;
            heard[m]   = 1'b0;
        endfunction

        function void write_reg(logic [mchw_pkg::IDXREG_W-1:0] idx,
                                logic [mchw_pkg::CFG_W-1:0] data);
            if (idx == mchw_pkg::REG_TOLERANCE)
                tolerance = data[mchw_pkg::TOLREG_W-1:0];
            else
                tmo_limit[idx] = data[mchw_pkg::TMO_W-1:0];
        endfunction

        // Apply one accepted transaction and queue the reports it causes.
        function void log_request(logic [mchw_pkg::KIND_W-1:0] kind,
                                  logic [mchw_pkg::MOD_W-1:0] mod,
                                  logic [mchw_pkg::TIME_W-1:0] now);
            status_report_t              rpt;
            logic [mchw_pkg::TIME_W-1:0] elapsed;
            logic [mchw_pkg::TOL_W-1:0]  tol;
            int                          crit_total;
            crit_total = 0;
            case (kind)
                mchw_pkg::KIND_HEARTBEAT:
                begin
                    if (mod < NUM_MODS)
                    begin
                        seen_ms[mod] = now;
                        misses[mod]  = '0;
                        heard[mod]   = 1'b1;
                    end
                end
                mchw_pkg::KIND_RESET_ONE:
                begin
                    if (mod < NUM_MODS)
                        forget(mod);
                end
                mchw_pkg::KIND_RESET_ALL:
                begin
                    for (int m = 0; m < NUM_MODS; m++)
                        forget(m);
                end
                default:
                begin
                    for (int m = 0; m < NUM_MODS; m++)
                    begin
                        rpt = '0;
                        rpt.module_index = mchw_pkg::MOD_W'(m);
                        rpt.beat_ok = 1'b1;
                        if (heard[m])
                        begin
                            elapsed = now - seen_ms[m];
                            tol = tolerance[mchw_pkg::TOL_W*m +: mchw_pkg::TOL_W];
                            if (elapsed > tmo_limit[m])
                            begin
                                if (misses[m] != mchw_pkg::LOSS_MAX)
                                    misses[m]++;
                                rpt.beat_ok  = 1'b0;
                                rpt.miss_run = misses[m];
                            end
                            else
                            begin
                                misses[m] = '0;
                            end
                            if (misses[m] > tol)
                            begin
                                rpt.is_critical = 1'b1;
                                crit_total++;
                            end
                        end
                        if (m == NUM_MODS - 1)
                        begin
                            rpt.last       = 1'b1;
                            rpt.crit_flag  = (crit_total != 0);
                            rpt.crit_tally = mchw_pkg::CCNT_W'(crit_total);
                        end
                        expected_reports.push_back(rpt);
                    end
                end
            endcase
        endfunction

        function void compare(string field, logic [mchw_pkg::LOSS_W-1:0] want,
                              logic [mchw_pkg::LOSS_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void score_report(status_report_t got);
            status_report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("report for module %0d with none outstanding", got.module_index);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare("module_index", want.module_index, got.module_index);
            compare("beat_ok", want.beat_ok, got.beat_ok);
            compare("miss_run", want.miss_run, got.miss_run);
            compare("is_critical", want.is_critical, got.is_critical);
            compare("crit_flag", want.crit_flag, got.crit_flag);
            compare("crit_tally", want.crit_tally, got.crit_tally);
            compare("last", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    logic [mchw_pkg::KIND_W-1:0]   kind;
    logic [mchw_pkg::MOD_W-1:0]    module_req;
    logic [mchw_pkg::TIME_W-1:0]   time_ms;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic [mchw_pkg::MOD_W-1:0]    module_index;
    logic                          beat_ok;
    logic [mchw_pkg::LOSS_W-1:0]   miss_run;
    logic                          is_critical;
    logic                          crit_flag;
    logic [mchw_pkg::CCNT_W-1:0]   crit_tally;
    logic                          last;
    logic                          cfg_we;
    logic [mchw_pkg::IDXREG_W-1:0] cfg_index;
    logic [mchw_pkg::CFG_W-1:0]    cfg_data;

    watchdog_tracker               tracker;
    int                            req_idle_pct;
    int                            rsp_stall_pct;
    logic [mchw_pkg::TIME_W-1:0]   now_ms;

    multi_channel_heartbeat_watchdog_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .kind         (kind),
        .module_req   (module_req),
        .time_ms      (time_ms),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .module_index (module_index),
        .beat_ok      (beat_ok),
        .miss_run     (miss_run),
        .is_critical  (is_critical),
        .crit_flag    (crit_flag),
        .crit_tally   (crit_tally),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Report side: random back-pressure, score each accepted transaction
    // ------------------------------------------------------------------------
    initial
    begin
        status_report_t got;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                got.module_index = module_index;
                got.beat_ok      = beat_ok;
                got.miss_run     = miss_run;
                got.is_critical  = is_critical;
                got.crit_flag    = crit_flag;
                got.crit_tally   = crit_tally;
                got.last         = last;
                tracker.score_report(got);
            end
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send(logic [mchw_pkg::KIND_W-1:0] k, logic [mchw_pkg::MOD_W-1:0] m,
                        logic [mchw_pkg::TIME_W-1:0] t);
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
        end
        req_valid  <= 1'b1;
        kind       <= k;
        module_req <= m;
        time_ms    <= t;
        do @(posedge clk); while (!req_ready);
        tracker.log_request(k, m, t);
    endtask

    // Hold off requests until every owed report is back, then let the walk settle.
    task automatic drain();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (tracker.expected_reports.size() != 0 && waited < DRAIN_CAP)
        begin
            @(posedge clk);
            waited++;
        end
        if (tracker.expected_reports.size() != 0)
        begin
            $error("%0d reports never arrived", tracker.expected_reports.size());
            tracker.errors++;
            tracker.expected_reports.delete();
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [mchw_pkg::IDXREG_W-1:0] idx,
                             logic [mchw_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(cfg_mode_t mode);
        logic [mchw_pkg::CFG_W-1:0] tmo;
        for (int i = 0; i < mchw_pkg::TIMEOUT_REGS; i++)
        begin
            case (mode)
                CFG_MIN: tmo = '0;
                CFG_MAX: tmo = mchw_pkg::CFG_W'({mchw_pkg::TMO_W{1'b1}});
                default: tmo = ($urandom_range(3) == 0)
                             ? mchw_pkg::CFG_W'($urandom_range(65535))
                             : mchw_pkg::CFG_W'($urandom_range(2000));
            endcase
            write_reg(mchw_pkg::IDXREG_W'(i), tmo);
        end
        case (mode)
            CFG_MIN: write_reg(mchw_pkg::REG_TOLERANCE, '0);
            CFG_MAX: write_reg(mchw_pkg::REG_TOLERANCE, {mchw_pkg::CFG_W{1'b1}});
            default: write_reg(mchw_pkg::REG_TOLERANCE, mchw_pkg::CFG_W'($urandom));
        endcase
    endtask

    // Mostly heartbeats and evaluates on an advancing clock, some resets and jumps.
    task automatic random_items(int count);
        int                          pick;
        logic [mchw_pkg::KIND_W-1:0] k;
        now_ms = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            pick = $urandom_range(99);
            if (pick < 80)
                now_ms += $urandom_range(600);
            else if (pick < 95)
                now_ms += $urandom_range(70000);
            else
                now_ms = $urandom;
            pick = $urandom_range(99);
            if (pick < 45)
                k = mchw_pkg::KIND_HEARTBEAT;
            else if (pick < 85)
                k = mchw_pkg::KIND_EVALUATE;
            else if (pick < 95)
                k = mchw_pkg::KIND_RESET_ONE;
            else
                k = mchw_pkg::KIND_RESET_ALL;
            send(k, mchw_pkg::MOD_W'($urandom_range(7)), now_ms);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tracker = new;
        tracker.power_on();
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        kind       <= mchw_pkg::KIND_HEARTBEAT;
        module_req <= '0;
        time_ms    <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values: nothing heard yet
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'd0);
        for (int m = 0; m < NUM_MODS; m++)
            send(mchw_pkg::KIND_HEARTBEAT, mchw_pkg::MOD_W'(m), 32'd1000);
        // module 1 sits exactly on its timeout, then one past it
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'd1300);
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'd1301);
        // far future: every module misses until all are critical
        repeat (4) send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'hFFFF_FFFF);
        // out-of-range module index is dropped
        send(mchw_pkg::KIND_HEARTBEAT, 3'd7, 32'd5);
        send(mchw_pkg::KIND_RESET_ONE, 3'd7, 32'd0);
        send(mchw_pkg::KIND_RESET_ONE, 3'd3, 32'd0);
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'hFFFF_FFFF);
        send(mchw_pkg::KIND_RESET_ALL, 3'd0, 32'd0);
        // elapsed time wraps through zero
        send(mchw_pkg::KIND_HEARTBEAT, 3'd0, 32'hFFFF_FF00);
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'h0000_0100);
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'd1245);
        send(mchw_pkg::KIND_HEARTBEAT, 3'd2, 32'h8000_0000);
        send(mchw_pkg::KIND_EVALUATE, 3'd0, 32'h8000_0000);

        drain();
        set_config(CFG_MIN);
        req_idle_pct = 59;
        random_items(RANDOM_ITEMS);

        drain();
        set_config(CFG_MAX);
        req_idle_pct  = 0;
        rsp_stall_pct = 59;
        random_items(RANDOM_ITEMS);

        drain();
        set_config(CFG_RANDOM);
        req_idle_pct  = 37;
        rsp_stall_pct = 37;
        random_items(RANDOM_ITEMS);

        drain();
        set_config(CFG_RANDOM);
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        random_items(RANDOM_ITEMS);

        // Zero timeouts: loss counts climb on every evaluate
        drain();
        set_config(CFG_MIN);
        now_ms = $urandom;
        for (int m = 0; m < NUM_MODS; m++)
            send(mchw_pkg::KIND_HEARTBEAT, mchw_pkg::MOD_W'(m), now_ms);
        for (int n = 0; n < SAT_EVALS; n++)
        begin
            now_ms += 1 + $urandom_range(50);
            if (n % 6 == 5)
                send(mchw_pkg::KIND_HEARTBEAT, 3'd4, now_ms);
            if (n == 8)
                send(mchw_pkg::KIND_RESET_ONE, 3'd5, now_ms);
            send(mchw_pkg::KIND_EVALUATE, mchw_pkg::MOD_W'($urandom_range(7)), now_ms);
        end

        drain();
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
